@@ rtl/hcbp_pkg.sv @@
`default_nettype none
package hcbp_pkg;

  localparam int SYMBOLS      = 256;
  localparam int MAX_CODE_LEN = 16;

  localparam int SYM_W   = 8;
  localparam int LEN_W   = 5;
  localparam int VALUE_W = 16;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 16;
  localparam int PEND_W  = BYTE_W - 1;
  localparam int PCNT_W  = $clog2(BYTE_W);

  localparam int TBL_AW  = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int ENTRY_W = LEN_W + VALUE_W;

  // Longest code that can be stored: bounded by the code field width too.
  localparam int EFF_MAX_LEN = (MAX_CODE_LEN < VALUE_W) ? MAX_CODE_LEN : VALUE_W;
  localparam int ACC_W       = PEND_W + VALUE_W;
  localparam int SUM_W       = $clog2(ACC_W + 1);

  localparam int MQ_DEPTH = 4;
  localparam int MQ_AW    = $clog2(MQ_DEPTH);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic               flush;
    logic [LEN_W-1:0]   len;
    logic [VALUE_W-1:0] code;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [CNT_W-1:0]  count;
  } result_t;

  function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] v);
    inc_sat = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

endpackage
`default_nettype wire

@@ rtl/hcbp_ram.sv @@
`default_nettype none
module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/hcbp_front.sv @@
`default_nettype none
module hcbp_front
  import hcbp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [1:0]         op,
  input  wire logic [SYM_W-1:0]   symbol,
  input  wire logic [LEN_W-1:0]   code_length,
  input  wire logic [VALUE_W-1:0] code_value,
  input  wire logic [MQ_AW:0]     mq_count,
  output logic                    cmd_valid,
  output cmd_t                    cmd
);

  logic              accept;
  logic              in_range;
  logic [TBL_AW-1:0] addr;
  logic [LEN_W-1:0]  len_clamped;
  logic              tbl_we;
  logic [ENTRY_W-1:0] rd_entry;
  logic [SYMBOLS-1:0] tbl_valid;
  logic              s1_valid;
  logic              s1_flush;
  logic              s1_hit;
  logic [LEN_W-1:0]  rd_len;

  // Room is counted for the item already in the lookup stage.
  assign full   = ({1'b0, mq_count} + (MQ_AW + 2)'(s1_valid)) >= (MQ_AW + 2)'(MQ_DEPTH);
  assign accept = push && !full;

  assign in_range = {1'b0, symbol} < (SYM_W + 1)'(SYMBOLS);
  assign addr     = TBL_AW'(symbol);
  assign tbl_we   = accept && (op_t'(op) == OP_LOAD) && in_range;

  always_comb begin
    if (code_length > LEN_W'(EFF_MAX_LEN)) begin
      len_clamped = LEN_W'(EFF_MAX_LEN);
    end else begin
      len_clamped = code_length;
    end
  end

  hcbp_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SYMBOLS)
  ) u_table (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(addr),
    .wdata({len_clamped, code_value}),
    .raddr(addr),
    .rdata(rd_entry)
  );

  // Entries never loaded since reset read as length zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_valid <= '0;
    end else if (tbl_we) begin
      tbl_valid[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && ((op_t'(op) == OP_ENCODE) || (op_t'(op) == OP_FLUSH));
    end
  end

  always_ff @(posedge clk) begin
    s1_flush <= (op_t'(op) == OP_FLUSH);
    s1_hit   <= in_range && tbl_valid[addr];
  end

  assign rd_len    = rd_entry[ENTRY_W-1 -: LEN_W];
  assign cmd_valid = s1_valid && (s1_flush || (s1_hit && (rd_len != '0)));
  assign cmd.flush = s1_flush;
  assign cmd.len   = rd_len;
  assign cmd.code  = rd_entry[VALUE_W-1:0];

endmodule
`default_nettype wire

@@ rtl/hcbp_cmd_queue.sv @@
`default_nettype none
module hcbp_cmd_queue
  import hcbp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   wr_en,
  input  wire cmd_t   wr_cmd,
  input  wire logic   rd_en,
  output logic        rd_valid,
  output cmd_t        rd_cmd,
  output logic [MQ_AW:0] count
);

  cmd_t             slots [MQ_DEPTH];
  logic [MQ_AW-1:0] wptr;
  logic [MQ_AW-1:0] rptr;

  assign rd_valid = (count != '0);
  assign rd_cmd   = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= wptr + MQ_AW'(1);
      end
      if (rd_en) begin
        rptr <= rptr + MQ_AW'(1);
      end
      count <= count + (MQ_AW + 1)'(wr_en) - (MQ_AW + 1)'(rd_en);
    end
  end

endmodule
`default_nettype wire

@@ rtl/hcbp_back.sv @@
`default_nettype none
module hcbp_back
  import hcbp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  input  wire cmd_t               cmd,
  output logic                    cmd_pop,
  output logic                    empty,
  input  wire logic               pop,
  output logic [BYTE_W-1:0]       packed_byte,
  output logic                    last_in_run,
  output logic [CNT_W-1:0]        bytes_emitted
);

  logic [PEND_W-1:0] pending_bits, pending_bits_next;
  logic [PCNT_W-1:0] pending_count, pending_count_next;
  logic [CNT_W-1:0]  byte_counter, byte_counter_next;

  result_t           oq [OQ_DEPTH];
  logic [OQ_AW-1:0]  oq_wptr;
  logic [OQ_AW-1:0]  oq_rptr;
  logic [OQ_AW:0]    oq_count;
  logic              oq_pop;

  logic [VALUE_W-1:0] code_masked;
  logic [ACC_W-1:0]   acc;
  logic [SUM_W-1:0]   total;
  logic [SUM_W-1:0]   remain;
  logic [BYTE_W-1:0]  byte_hi;
  logic [BYTE_W-1:0]  byte_lo;
  logic [CNT_W-1:0]   cnt1;
  logic [CNT_W-1:0]   cnt2;
  logic [1:0]         nres;
  result_t            res0;
  result_t            res1;

  // Two free result slots are needed, since one command makes up to two bytes.
  assign cmd_pop = cmd_valid && (oq_count <= (OQ_AW + 1)'(OQ_DEPTH - 2));
  assign empty   = (oq_count == '0);
  assign oq_pop  = pop && !empty;

  assign packed_byte   = oq[oq_rptr].data;
  assign last_in_run   = oq[oq_rptr].last;
  assign bytes_emitted = oq[oq_rptr].count;

  assign cnt1 = inc_sat(byte_counter);
  assign cnt2 = inc_sat(cnt1);

  always_comb begin
    code_masked = cmd.code & ~({VALUE_W{1'b1}} << cmd.len);
    acc         = (ACC_W'(pending_bits) << cmd.len) | ACC_W'(code_masked);
    total       = SUM_W'(pending_count) + SUM_W'(cmd.len);
    byte_hi     = BYTE_W'(acc >> (total - SUM_W'(BYTE_W)));
    byte_lo     = BYTE_W'(acc >> (total - SUM_W'(2 * BYTE_W)));

    nres               = 2'd0;
    res0               = '0;
    res1               = '0;
    remain             = total;
    pending_bits_next  = pending_bits;
    pending_count_next = pending_count;
    byte_counter_next  = byte_counter;

    if (cmd.flush) begin
      // Pending bits go to the top of the final byte, zero-padded below.
      res0.data  = BYTE_W'(BYTE_W'(pending_bits) <<
                           ((PCNT_W + 1)'(BYTE_W) - (PCNT_W + 1)'(pending_count)));
      res0.last  = 1'b1;
      res0.count = cnt1;
      nres       = (pending_count != '0) ? 2'd1 : 2'd0;
      pending_bits_next  = '0;
      pending_count_next = '0;
      byte_counter_next  = '0;
    end else begin
      if (total >= SUM_W'(2 * BYTE_W)) begin
        nres   = 2'd2;
        res0   = '{data: byte_hi, last: 1'b0, count: cnt1};
        res1   = '{data: byte_lo, last: 1'b1, count: cnt2};
        remain = total - SUM_W'(2 * BYTE_W);
        byte_counter_next = cnt2;
      end else if (total >= SUM_W'(BYTE_W)) begin
        nres   = 2'd1;
        res0   = '{data: byte_hi, last: 1'b1, count: cnt1};
        remain = total - SUM_W'(BYTE_W);
        byte_counter_next = cnt1;
      end
      pending_bits_next  = PEND_W'(acc) & ~({PEND_W{1'b1}} << remain);
      pending_count_next = PCNT_W'(remain);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
      byte_counter  <= '0;
    end else if (cmd_pop) begin
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
      byte_counter  <= byte_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && (nres != 2'd0)) begin
      oq[oq_wptr] <= res0;
    end
    if (cmd_pop && (nres == 2'd2)) begin
      oq[oq_wptr + OQ_AW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wptr  <= '0;
      oq_rptr  <= '0;
      oq_count <= '0;
    end else begin
      if (cmd_pop) begin
        oq_wptr <= oq_wptr + OQ_AW'(nres);
      end
      if (oq_pop) begin
        oq_rptr <= oq_rptr + OQ_AW'(1);
      end
      oq_count <= oq_count + (cmd_pop ? (OQ_AW + 1)'(nres) : '0)
                  - (OQ_AW + 1)'(oq_pop);
    end
  end

endmodule
`default_nettype wire

@@ rtl/huffman_code_bit_packer.sv @@
// Huffman encoder with MSB-first byte packing. Load items fill a 256-entry
// code table (length and right-aligned code bits); encode items append the
// symbol's code to a bit accumulator and deliver each finished byte; a flush
// item delivers the zero-padded partial byte, if any, and restarts the byte
// count. The block takes one input item per cycle while full is low: a table
// lookup stage feeds a four-entry command queue, and the packer retires one
// command per cycle, while two result slots are free, into a four-entry
// result queue. Since an encode can finish two bytes and one result transfer
// happens per cycle, long codes limit the sustained rate to the pop rate of
// one byte per cycle. A result passes the lookup register and both queues.
// Table lengths read as zero after reset, so no clearing time is needed.
`default_nettype none
module huffman_code_bit_packer
  import hcbp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [1:0]         op,
  input  wire logic [SYM_W-1:0]   symbol,
  input  wire logic [LEN_W-1:0]   code_length,
  input  wire logic [VALUE_W-1:0] code_value,
  output logic                    empty,
  input  wire logic               pop,
  output logic [BYTE_W-1:0]       packed_byte,
  output logic                    last_in_run,
  output logic [CNT_W-1:0]        bytes_emitted
);

  logic           fe_valid;
  cmd_t           fe_cmd;
  logic [MQ_AW:0] mq_count;
  logic           mq_valid;
  cmd_t           mq_cmd;
  logic           mq_pop;

  hcbp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .op         (op),
    .symbol     (symbol),
    .code_length(code_length),
    .code_value (code_value),
    .mq_count   (mq_count),
    .cmd_valid  (fe_valid),
    .cmd        (fe_cmd)
  );

  hcbp_cmd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fe_valid),
    .wr_cmd  (fe_cmd),
    .rd_en   (mq_pop),
    .rd_valid(mq_valid),
    .rd_cmd  (mq_cmd),
    .count   (mq_count)
  );

  hcbp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (mq_valid),
    .cmd          (mq_cmd),
    .cmd_pop      (mq_pop),
    .empty        (empty),
    .pop          (pop),
    .packed_byte  (packed_byte),
    .last_in_run  (last_in_run),
    .bytes_emitted(bytes_emitted)
  );

endmodule
`default_nettype wire

@@ bench/tb_huffman_code_bit_packer.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_huffman_code_bit_packer;
  import hcbp_pkg::*;

  logic               clk;
  logic               rst;
  logic               push;
  logic               full;
  logic [1:0]         op;
  logic [SYM_W-1:0]   symbol;
  logic [LEN_W-1:0]   code_length;
  logic [VALUE_W-1:0] code_value;
  logic               empty;
  logic               pop;
  logic [BYTE_W-1:0]  packed_byte;
  logic               last_in_run;
  logic [CNT_W-1:0]   bytes_emitted;

  huffman_code_bit_packer DUT (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .op            (op),
    .symbol        (symbol),
    .code_length   (code_length),
    .code_value    (code_value),
    .empty         (empty),
    .pop           (pop),
    .packed_byte   (packed_byte),
    .last_in_run   (last_in_run),
    .bytes_emitted (bytes_emitted)
  );

  // Encoder state as the bench sees it.
  logic [LEN_W-1:0]   length_of [0:255];
  logic [VALUE_W-1:0] code_of [0:255];
  logic [31:0]        held_bits;
  int unsigned        held_count;
  logic [CNT_W-1:0]   message_bytes;

  result_t            pending_bytes[$];
  result_t            oldest;
  int                 error_count;
  bit                 tx_idle_en;
  bit                 rx_idle_en;
  int                 rx_hold_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic emit_byte(input logic [7:0] value, input logic is_last);
    result_t r;
    if (message_bytes != 16'hFFFF) begin
      message_bytes = message_bytes + 16'd1;
    end
    r.data  = value;
    r.last  = is_last;
    r.count = message_bytes;
    pending_bytes.push_back(r);
  endtask

  task automatic encode_item(input logic [1:0] o, input logic [7:0] s,
                             input logic [4:0] l, input logic [15:0] v);
    int unsigned eff;
    logic [31:0] acc;
    case (o)
      OP_LOAD: begin
        eff = l;
        if (eff > MAX_CODE_LEN) eff = MAX_CODE_LEN;
        if (eff > VALUE_W) eff = VALUE_W;
        length_of[s] = eff[LEN_W-1:0];
        code_of[s]   = v;
      end
      OP_ENCODE: begin
        eff = length_of[s];
        if (eff != 0) begin
          acc = (held_bits << eff) | ({16'd0, code_of[s]} & ((32'd1 << eff) - 32'd1));
          held_count = held_count + eff;
          while (held_count >= 8) begin
            held_count = held_count - 8;
            emit_byte(8'(acc >> held_count), held_count < 8);
          end
          held_bits = acc & ((32'd1 << held_count) - 32'd1);
        end
      end
      OP_FLUSH: begin
        if (held_count != 0) begin
          emit_byte(8'(held_bits << (8 - held_count)), 1'b1);
        end
        held_bits     = '0;
        held_count    = 0;
        message_bytes = '0;
      end
      default: begin
      end
    endcase
  endtask

  // Results are checked before the same edge's input is modeled; a result
  // never leaves the block in the cycle its item is accepted.
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected result: expected none, got byte %h last %b count %0d",
                 $time, packed_byte, last_in_run, bytes_emitted);
        error_count++;
      end else begin
        oldest = pending_bytes.pop_front();
        if (packed_byte !== oldest.data) begin
          $display("%0t: packed_byte mismatch: expected %h, got %h",
                   $time, oldest.data, packed_byte);
          error_count++;
        end
        if (last_in_run !== oldest.last) begin
          $display("%0t: last_in_run mismatch: expected %b, got %b",
                   $time, oldest.last, last_in_run);
          error_count++;
        end
        if (bytes_emitted !== oldest.count) begin
          $display("%0t: bytes_emitted mismatch: expected %0d, got %0d",
                   $time, oldest.count, bytes_emitted);
          error_count++;
        end
      end
    end
    if (!rst && push && !full) begin
      encode_item(op, symbol, code_length, code_value);
    end
  end

  // Result side: random stalls, or one long hold-off when requested.
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        pop <= 1'b0;
        repeat (rx_hold_cycles - 1) @(negedge clk);
        rx_hold_cycles = 0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Entered and left at a falling edge; returns once the item is transferred.
  task automatic send_item(input logic [1:0] o, input logic [7:0] s,
                           input logic [4:0] l, input logic [15:0] v);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    push        <= 1'b1;
    op          <= o;
    symbol      <= s;
    code_length <= l;
    code_value  <= v;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic test_directed();
    send_item(OP_ENCODE, 8'h00, 5'd0, 16'h0000);   // absent symbol
    send_item(OP_FLUSH, 8'h00, 5'd0, 16'h0000);    // nothing pending
    send_item(OP_NONE, 8'hFF, 5'd31, 16'hFFFF);    // unused op
    send_item(OP_LOAD, 8'hFF, 5'd16, 16'hFFFF);
    send_item(OP_LOAD, 8'h00, 5'd1, 16'hFFFE);     // stray bits above the code
    send_item(OP_LOAD, 8'hA5, 5'd31, 16'h5A5A);    // overlong length is clamped
    send_item(OP_LOAD, 8'h03, 5'd17, 16'h8001);
    send_item(OP_LOAD, 8'h01, 5'd3, 16'h0005);
    send_item(OP_ENCODE, 8'h00, 5'd0, 16'h0000);
    send_item(OP_ENCODE, 8'h01, 5'd31, 16'hFFFF);
    send_item(OP_ENCODE, 8'hFF, 5'd0, 16'h0000);
    send_item(OP_ENCODE, 8'hA5, 5'd0, 16'h0000);
    send_item(OP_ENCODE, 8'h03, 5'd0, 16'h0000);
    send_item(OP_FLUSH, 8'hFF, 5'd31, 16'hFFFF);
    send_item(OP_FLUSH, 8'h00, 5'd0, 16'h0000);
    send_item(OP_ENCODE, 8'h01, 5'd0, 16'h0000);
    send_item(OP_FLUSH, 8'h00, 5'd0, 16'h0000);
    send_item(OP_LOAD, 8'h01, 5'd0, 16'hFFFF);     // entry made absent again
    send_item(OP_ENCODE, 8'h01, 5'd0, 16'h0000);
    send_item(OP_ENCODE, 8'h00, 5'd0, 16'h0000);
    send_item(OP_FLUSH, 8'h00, 5'd0, 16'h0000);
  endtask

  task automatic test_random(input int count);
    int pick;
    logic [4:0] len;
    for (int s = 0; s < 256; s++) begin
      send_item(OP_LOAD, 8'(s), 5'($urandom_range(1, 16)), 16'($urandom));
    end
    for (int i = 0; i < count; i++) begin
      if (i == (count * 3) / 4) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        len = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                          : 5'($urandom_range(1, 16));
        send_item(OP_LOAD, 8'($urandom), len, 16'($urandom));
      end else if (pick < 88) begin
        send_item(OP_ENCODE, 8'($urandom), 5'($urandom), 16'($urandom));
      end else if (pick < 96) begin
        send_item(OP_FLUSH, 8'($urandom), 5'($urandom), 16'($urandom));
      end else begin
        send_item(OP_NONE, 8'($urandom), 5'($urandom), 16'($urandom));
      end
    end
    send_item(OP_FLUSH, 8'h00, 5'd0, 16'h0000);
  endtask

  // The receiver stops for a long stretch while two-byte codes keep coming,
  // so both queues fill and the block refuses further transfers.
  task automatic test_backpressure();
    send_item(OP_LOAD, 8'hC3, 5'd16, 16'($urandom));
    rx_hold_cycles = 300;
    for (int i = 0; i < 40; i++) begin
      send_item(OP_ENCODE, 8'hC3, 5'd0, 16'h0000);
    end
    send_item(OP_FLUSH, 8'h00, 5'd0, 16'h0000);
  endtask

  initial begin
    rst            = 1'b1;
    push           = 1'b0;
    op             = OP_LOAD;
    symbol         = '0;
    code_length    = '0;
    code_value     = '0;
    error_count    = 0;
    tx_idle_en     = 1'b1;
    rx_idle_en     = 1'b1;
    rx_hold_cycles = 0;
    held_bits      = '0;
    held_count     = 0;
    message_bytes  = '0;
    for (int s = 0; s < 256; s++) begin
      length_of[s] = '0;
      code_of[s]   = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random(1680);
    test_backpressure();
    push <= 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
